/* src/sat_pkg.sv */
// Shared types and constants for the sorted array table.
package sat_pkg;

  // Table size and stored key width.
  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;

  // Fixed field widths of the stream words.
  localparam int ACT_W     = 2;
  localparam int KEY_IN_W  = 32;
  localparam int IDX_IN_W  = 4;
  localparam int ST_W      = 2;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 5;
  localparam int CAP_W     = 5;

  // Packed stream word widths, rounded up to whole bytes.
  localparam int IN_BITS  = ACT_W + KEY_IN_W + IDX_IN_W;
  localparam int OUT_BITS = ST_W + VAL_W + CNT_OUT_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Bit positions inside the stream words.
  localparam int IN_KEY_LSB  = ACT_W;
  localparam int IN_IDX_LSB  = ACT_W + KEY_IN_W;
  localparam int OUT_VAL_LSB = ST_W;
  localparam int OUT_CNT_LSB = ST_W + VAL_W;

  // Internal widths derived from the table size.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (IDX_IN_W > CNT_W) ? IDX_IN_W : CNT_W;
  localparam int LIM_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_INDEX = 2'd2
  } status_e;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic ins;    // insert operation this cycle
    logic rem;    // remove operation this cycle
    logic occ;    // cell holds a stored entry
    logic shift;  // cell sits at or above the removed index
  } sat_cell_ctl_t;

endpackage

/* src/sorted_array_table.sv */
// Sorted array table: a chain of key cells kept in ascending order.
//
// Input words arrive on s_axis_*: action, key and index packed in tdata.
// Insert places the key ahead of equal keys and returns the position taken;
// lookup returns the key at an index; remove returns and deletes it.
// Full tables and indexes at or beyond the count give an error status and
// leave the table alone. Every input word gives exactly one result word on
// m_axis_*: status, value and the entry count after the operation.
//
// All cells compare against the new key and shift in the same cycle, so an
// operation completes in the cycle it is accepted and its result appears in
// the output register in the next cycle. One word is taken per cycle while
// the output register is empty or being drained; when the receiver stalls,
// the result is held and s_axis_tready drops until it is taken.
//
// Reset empties the table and sets capacity to 16. Users must write capacity
// register via cfg_we_i/cfg_wdata_i with no work outstanding (not enforced).
module sorted_array_table
  import sat_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] action, [33:2] key, [37:34] index
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [33:2] value, [38:34] count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i
);

  logic [CAP_W-1:0]       cap_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  action_e                act;
  logic [KEY_BITS-1:0]    new_key;
  logic [IDX_IN_W-1:0]    idx_in;
  logic [CMP_W-1:0]       idx_cmp;
  logic [LIM_W-1:0]       lim;
  logic                   accept, full, idx_ok, do_ins, do_rem;

  logic [KEY_BITS-1:0]    keys [DEPTH];
  logic [DEPTH-1:0]       less;
  logic [DEPTH-1:0]       bound;
  logic [IDX_W-1:0]       pos;
  sat_cell_ctl_t          ctl [DEPTH];

  status_e                st;
  logic [VAL_W-1:0]       val;

  // Input word unpacking.
  assign act     = action_e'(s_axis_tdata[ACT_W-1:0]);
  assign new_key = KEY_BITS'(s_axis_tdata[IN_KEY_LSB +: KEY_IN_W]);
  assign idx_in  = s_axis_tdata[IN_IDX_LSB +: IDX_IN_W];
  assign idx_cmp = CMP_W'(idx_in);

  // Output register frees up when empty or drained this cycle.
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Effective limit is the smaller of capacity and table depth.
  assign lim    = (LIM_W'(cap_q) < LIM_W'(DEPTH)) ? LIM_W'(cap_q) : LIM_W'(DEPTH);
  assign full   = LIM_W'(cnt_q) >= lim;
  assign idx_ok = idx_cmp < CMP_W'(cnt_q);
  assign do_ins = accept && (act == ACT_INSERT) && !full;
  assign do_rem = accept && (act == ACT_REMOVE) && idx_ok;

  // The cell chain.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key, right_key;
    logic                left_less;

    if (i == 0) begin : g_first
      assign left_key  = new_key;
      assign left_less = 1'b1;
    end else begin : g_mid
      assign left_key  = keys[i-1];
      assign left_less = less[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    assign ctl[i].ins   = do_ins;
    assign ctl[i].rem   = do_rem;
    assign ctl[i].occ   = CNT_W'(i) < cnt_q;
    assign ctl[i].shift = CMP_W'(i) >= idx_cmp;

    // The insert point is where the run of smaller keys ends.
    assign bound[i] = left_less && !less[i];

    sat_cell u_cell (
      .clk_i       (clk_i),
      .new_key_i   (new_key),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .left_less_i (left_less),
      .ctl_i       (ctl[i]),
      .key_o       (keys[i]),
      .less_o      (less[i])
    );
  end

  // Encode the one-hot insert point into a position.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (bound[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  // Result and next count.
  always_comb begin
    st    = ST_OK;
    val   = '0;
    cnt_d = cnt_q;
    case (act)
      ACT_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          val   = VAL_W'(pos);
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ACT_LOOKUP, ACT_REMOVE: begin
        if (!idx_ok) begin
          st = ST_INDEX;
        end else begin
          val = VAL_W'(keys[IDX_W'(idx_in)]);
          if (act == ACT_REMOVE) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  always_comb begin
    out_data_d = '0;
    out_data_d[ST_W-1:0]                = st;
    out_data_d[OUT_VAL_LSB +: VAL_W]    = val;
    out_data_d[OUT_CNT_LSB +: CNT_OUT_W] = CNT_OUT_W'(cnt_d);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* src/sat_cell.sv */
// One cell of the sorted chain: holds a key and shifts with its neighbors.
module sat_cell
  import sat_pkg::*;
(
  input  logic                clk_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic                left_less_i,
  input  sat_cell_ctl_t       ctl_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                less_o
);

  logic [KEY_BITS-1:0] key_q, key_d;

  // An occupied cell whose key is below the new key stays put on insert.
  assign less_o = ctl_i.occ && (key_q < new_key_i);

  // The first cell not below the new key takes it; later cells take the left key.
  always_comb begin
    key_d = key_q;
    if (ctl_i.ins && !less_o) begin
      key_d = left_less_i ? new_key_i : left_key_i;
    end else if (ctl_i.rem && ctl_i.shift) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

/* src/sat_checker.sv */
// Port-level checks for the sorted array table, bound to the top level.
module sat_checker
  import sat_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [ST_W-1:0]      o_st;
  logic [VAL_W-1:0]     o_val;
  logic [CNT_OUT_W-1:0] o_cnt;

  assign o_st  = m_axis_tdata[ST_W-1:0];
  assign o_val = m_axis_tdata[OUT_VAL_LSB +: VAL_W];
  assign o_cnt = m_axis_tdata[OUT_CNT_LSB +: CNT_OUT_W];

  // A stalled result word holds its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Every accepted word produces a result in the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word gave no result");

  // The count never exceeds the table depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> CNT_OUT_W'(DEPTH) >= o_cnt)
    else $error("count beyond table depth");

  // An error result carries a zero value.
  a_errval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (o_st == ST_FULL || o_st == ST_INDEX) |-> o_val == '0)
    else $error("error result with nonzero value");

endmodule

bind sorted_array_table sat_checker u_sat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
